@@ rtl/dgdf_pkg.sv @@
package dgdf_pkg;

  localparam logic [7:0] MAX_BUFF     = 8'd128;
  localparam logic [7:0] HEADER_BYTES = 8'd4;
  localparam logic [7:0] DIGIT_LOW    = 8'h30;
  localparam logic [7:0] DIGIT_HIGH   = 8'h39;

  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_END    = 2'd1;
  localparam logic [1:0] REG_ENABLE = 2'd2;

  localparam logic [7:0] START_RESET = 8'd123;
  localparam logic [7:0] END_RESET   = 8'd125;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_NOT_ACTIVE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic       enable;
  } cfg_t;

endpackage

@@ rtl/datagram_deframer_length_check_top.sv @@
// Deframes a byte stream: bytes are ignored until the start sentinel, the first four frame
// bytes give a decimal length, the fifth the frame type, later bytes leave as payload words
// (tuser 0) and the end sentinel gives a status word (tuser 1, tlast 1) with the length
// verdict; a frame reaching the buffer limit ends in an overflow status. While disabled each
// byte gives a not-active status. One byte is taken every clock cycle unless a held output
// word stalls the stage; a byte is held in the input register, its result is registered in
// the output register, and the frame state is updated once per byte.
module datagram_deframer_length_check_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // rx_byte
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // data_byte, frame_type, status, payload_length, zero fill
  output logic [31:0]                 m_axis_tdata,
  output logic                        m_axis_tuser,   // kind
  output logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dgdf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef struct packed {
    logic                kind;
    logic [7:0]          data_byte;
    logic [7:0]          frame_type;
    dgdf_pkg::status_e   status;
    logic [7:0]          payload_length;
    logic                last;
  } res_t;

  typedef struct packed {
    logic        in_frame;
    logic [7:0]  byte_count;
    logic [13:0] declared_length;
    logic        digits_open;
    logic [7:0]  type_held;
  } frame_t;

  localparam frame_t FrameClear = '{
    in_frame: 1'b0, byte_count: 8'd0, declared_length: 14'd0,
    digits_open: 1'b1, type_held: 8'd0
  };

  dgdf_pkg::cfg_t cfg;

  dgdf_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  frame_t     frame_q, frame_d;
  logic       out_valid_q;
  res_t       out_q;
  res_t       res;
  logic       produce;
  logic       advance;
  logic [7:0] count_next;
  logic [14:0] expected;
  logic       is_digit;
  logic       length_ok;

  assign advance       = in_valid_q & (~produce | ~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  assign count_next = frame_q.byte_count + 8'd1;
  assign expected   = {1'b0, frame_q.declared_length} + 15'(dgdf_pkg::HEADER_BYTES);
  assign is_digit   = (in_byte_q >= dgdf_pkg::DIGIT_LOW) && (in_byte_q <= dgdf_pkg::DIGIT_HIGH);
  assign length_ok  = (frame_q.declared_length != 14'd0) &&
                      (expected == {7'd0, frame_q.byte_count});

  always_comb begin
    frame_d = frame_q;
    produce = 1'b0;
    res     = '{kind: 1'b0, data_byte: 8'd0, frame_type: 8'd0,
                status: dgdf_pkg::ST_OK, payload_length: 8'd0, last: 1'b0};
    if (!cfg.enable) begin
      frame_d    = FrameClear;
      produce    = 1'b1;
      res.kind   = 1'b1;
      res.status = dgdf_pkg::ST_NOT_ACTIVE;
    end else if (!frame_q.in_frame) begin
      if (in_byte_q == cfg.start_byte) begin
        frame_d          = FrameClear;
        frame_d.in_frame = 1'b1;
      end
    end else if (in_byte_q == cfg.end_byte || count_next >= dgdf_pkg::MAX_BUFF) begin
      // frame closes: length verdict on end sentinel, otherwise buffer overflow
      frame_d            = FrameClear;
      produce            = 1'b1;
      res.kind           = 1'b1;
      res.frame_type     = frame_q.type_held;
      res.payload_length = frame_q.declared_length[7:0] - 8'd1;
      res.last           = 1'b1;
      if (in_byte_q == cfg.end_byte) begin
        res.status = length_ok ? dgdf_pkg::ST_OK : dgdf_pkg::ST_BAD_LENGTH;
      end else begin
        res.status = dgdf_pkg::ST_OVERFLOW;
      end
    end else begin
      frame_d.byte_count = count_next;
      if (frame_q.byte_count < dgdf_pkg::HEADER_BYTES) begin
        if (frame_q.digits_open && is_digit) begin
          frame_d.declared_length = 14'((frame_q.declared_length << 3) +
                                        (frame_q.declared_length << 1) +
                                        14'(in_byte_q[3:0]));
        end else begin
          frame_d.digits_open = 1'b0;
        end
      end else if (frame_q.byte_count == dgdf_pkg::HEADER_BYTES) begin
        frame_d.type_held = in_byte_q;
      end else begin
        produce        = 1'b1;
        res.data_byte  = in_byte_q;
        res.frame_type = frame_q.type_held;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= FrameClear;
    end else if (advance) begin
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && produce) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {6'd0, out_q.payload_length, out_q.status,
                          out_q.frame_type, out_q.data_byte};

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.byte_count < dgdf_pkg::MAX_BUFF)
    else $error("frame byte count reached buffer limit");

  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (!m_axis_tlast && m_axis_tdata[25:16] == 10'd0))
    else $error("payload word carries status fields");

  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
    else $error("frame end on payload word");

  a_idle_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !cfg.enable) |=> !frame_q.in_frame)
    else $error("frame kept while disabled");

endmodule

@@ rtl/dgdf_apb_regs.sv @@
module dgdf_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dgdf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output dgdf_pkg::cfg_t              cfg_o
);

  logic [7:0] start_q;
  logic [7:0] end_q;
  logic       enable_q;
  logic       wr_en;
  logic [1:0] index;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign index  = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= dgdf_pkg::START_RESET;
      end_q    <= dgdf_pkg::END_RESET;
      enable_q <= 1'b0;
    end else if (wr_en) begin
      unique case (index)
        dgdf_pkg::REG_START:  start_q  <= pwdata[7:0];
        dgdf_pkg::REG_END:    end_q    <= pwdata[7:0];
        dgdf_pkg::REG_ENABLE: enable_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      dgdf_pkg::REG_START:  prdata = {24'd0, start_q};
      dgdf_pkg::REG_END:    prdata = {24'd0, end_q};
      dgdf_pkg::REG_ENABLE: prdata = {31'd0, enable_q};
      default:              prdata = 32'd0;
    endcase
  end

  assign cfg_o = '{start_byte: start_q, end_byte: end_q, enable: enable_q};

endmodule
